// File: sv/path_bandwidth_admission_core_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the path bandwidth admission core
// ---------------------------------------------------------------------------
`ifndef PATH_BANDWIDTH_ADMISSION_CORE_ASSERT_SVH
`define PATH_BANDWIDTH_ADMISSION_CORE_ASSERT_SVH

// checked only outside reset
`define PBA_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define PBA_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: sv/pba_pkg.sv
// ---------------------------------------------------------------------------
// pba_pkg
// Shared constants and types of the path bandwidth admission core.
// ---------------------------------------------------------------------------
package pba_pkg;

  localparam int MAX_LINKS = 1024;
  localparam int CAP_WIDTH = 32;

  localparam int LINK_W = 10;
  localparam int NODE_W = 11;
  localparam int AMT_W  = 32;
  localparam int CFG_W  = 11;

  localparam int ADDR_W = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int LIM_W  = ($clog2(MAX_LINKS + 1) > NODE_W) ? $clog2(MAX_LINKS + 1) : NODE_W;
  localparam int CMP_W  = (CAP_WIDTH > AMT_W) ? CAP_WIDTH : AMT_W;

  typedef enum logic [0:0] {
    OP_LOAD    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_UPD,
    ST_UPD_END,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t               op;
    logic [AMT_W-1:0]  amount;
    logic [NODE_W-1:0] node_b;
    logic [NODE_W-1:0] node_a;
    logic [LINK_W-1:0] link_index;
  } req_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [CAP_WIDTH-1:0] wdata;
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
  } ram_req_t;

endpackage

// File: sv/pba_link_ram.sv
// ---------------------------------------------------------------------------
// pba_link_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ---------------------------------------------------------------------------
module pba_link_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/pba_ctrl.sv
// ---------------------------------------------------------------------------
// pba_ctrl
// Request sequencer: range check, capacity scan over the path, then, when
// the workload fits, a read-modify-write pass that reserves it on every link.
// ---------------------------------------------------------------------------
module pba_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pba_pkg::LIM_W-1:0]     limit,
  input  logic                          s_valid,
  output logic                          s_ready,
  input  pba_pkg::req_t                 req,
  output logic                          m_valid,
  input  logic                          m_ready,
  output logic                          m_accepted,
  output logic                          m_range_error,
  output pba_pkg::ram_req_t             ram,
  input  logic [pba_pkg::CAP_WIDTH-1:0] ram_q
);
  import pba_pkg::*;

  state_t              state, state_next;
  logic [ADDR_W-1:0]   lo, last, ptr, pend_addr;
  logic                pend;
  logic                fits;
  logic [AMT_W-1:0]    amt;
  logic                res_acc, res_err;

  logic                take, is_req, bad, same, ge, out_free;
  logic [NODE_W-1:0]   lo_n, hi_n;

  assign take     = s_valid && s_ready;
  assign is_req   = (req.op == OP_REQUEST);
  assign bad      = (LIM_W'(req.node_a) > limit) || (LIM_W'(req.node_b) > limit);
  assign same     = (req.node_a == req.node_b);
  assign lo_n     = (req.node_a < req.node_b) ? req.node_a : req.node_b;
  assign hi_n     = (req.node_a < req.node_b) ? req.node_b : req.node_a;
  assign ge       = CMP_W'(ram_q) >= CMP_W'(amt);
  assign out_free = !m_valid || m_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (take && is_req) begin
          state_next = (bad || same) ? ST_RESULT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ptr == last) begin
          state_next = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_next = (fits && ge) ? ST_UPD : ST_RESULT;
      end
      ST_UPD: begin
        if (ptr == last) begin
          state_next = ST_UPD_END;
        end
      end
      ST_UPD_END: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_ready = (state == ST_IDLE);
    ram     = '0;
    unique case (state)
      ST_IDLE: begin
        // loads beyond the store are dropped
        ram.we    = take && !is_req && (32'(req.link_index) < 32'(MAX_LINKS));
        ram.waddr = ADDR_W'(req.link_index);
        ram.wdata = CAP_WIDTH'(req.amount);
      end
      ST_SCAN: begin
        ram.re    = 1'b1;
        ram.raddr = ptr;
      end
      ST_UPD: begin
        ram.re    = 1'b1;
        ram.raddr = ptr;
        ram.we    = pend;
        ram.waddr = pend_addr;
        ram.wdata = ram_q - CAP_WIDTH'(amt);
      end
      ST_UPD_END: begin
        ram.we    = pend;
        ram.waddr = pend_addr;
        ram.wdata = ram_q - CAP_WIDTH'(amt);
      end
      default: begin
        ram = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pend    <= 1'b0;
      m_valid <= 1'b0;
    end else begin
      state   <= state_next;
      pend    <= (state == ST_SCAN) || (state == ST_UPD);
      if (state == ST_RESULT && out_free) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr <= ptr;
    unique case (state)
      ST_IDLE: begin
        if (take) begin
          lo      <= ADDR_W'(lo_n);
          ptr     <= ADDR_W'(lo_n);
          last    <= ADDR_W'(hi_n - NODE_W'(1));
          amt     <= req.amount;
          fits    <= 1'b1;
          res_err <= bad;
          res_acc <= !bad && same;
        end
      end
      ST_SCAN: begin
        ptr <= ptr + ADDR_W'(1);
        if (pend) begin
          fits <= fits && ge;
        end
      end
      ST_SCAN_END: begin
        ptr     <= lo;
        res_acc <= fits && ge;
      end
      ST_UPD: begin
        ptr <= ptr + ADDR_W'(1);
      end
      default: begin
      end
    endcase
    if (state == ST_RESULT && out_free) begin
      m_accepted    <= res_acc;
      m_range_error <= res_err;
    end
  end

endmodule

// File: sv/path_bandwidth_admission_core.sv
// ---------------------------------------------------------------------------
// path_bandwidth_admission_core
// Link capacity store and admission control for a chain of nodes.
// ---------------------------------------------------------------------------
// Input stream: tuser selects a load (0) or a bandwidth request (1). A load
// writes one link capacity and gives no result. A request gives one result:
// accepted in tdata bit 0, range_error in tuser. A request first scans the
// capacities of its path and, when the workload fits, reserves it on every
// link of the path; a request that does not fit skips the reserve pass.
// Requests with equal nodes or an out-of-range node skip both passes. The
// single read port of the capacity RAM reads one link per cycle in each
// pass. One item is in work at a time; the next item is taken at the edge
// after the result enters the output register, even while it waits there.
// A stalled receiver holds the result; a finished request then waits
// until the output register is free. Reset clears the sequencer, the
// output valid and sets links_in_use to 1024; capacities keep their
// contents and must be loaded before a request reads them. links_in_use is
// written through cfg_we / cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module path_bandwidth_admission_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [pba_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [63:0]               s_axis_tdata,  // link_index, node_a, node_b, amount
  input  logic [0:0]                s_axis_tuser,  // op
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [7:0]                m_axis_tdata,  // accepted, zero pad
  output logic [0:0]                m_axis_tuser   // range_error
);
  import pba_pkg::*;

  logic [CFG_W-1:0]     links_in_use;
  logic [LIM_W-1:0]     limit;
  req_t                 req;
  ram_req_t             ram;
  logic [CAP_WIDTH-1:0] ram_q;
  logic                 accepted, range_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      links_in_use <= CFG_W'(1024);
    end else if (cfg_we) begin
      links_in_use <= cfg_wdata;
    end
  end

  assign limit = (LIM_W'(links_in_use) > LIM_W'(MAX_LINKS)) ? LIM_W'(MAX_LINKS)
                                                            : LIM_W'(links_in_use);

  always_comb begin
    req.op         = op_t'(s_axis_tuser[0]);
    req.link_index = s_axis_tdata[9:0];
    req.node_a     = s_axis_tdata[20:10];
    req.node_b     = s_axis_tdata[31:21];
    req.amount     = s_axis_tdata[63:32];
  end

  pba_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .limit         (limit),
    .s_valid       (s_axis_tvalid),
    .s_ready       (s_axis_tready),
    .req           (req),
    .m_valid       (m_axis_tvalid),
    .m_ready       (m_axis_tready),
    .m_accepted    (accepted),
    .m_range_error (range_error),
    .ram           (ram),
    .ram_q         (ram_q)
  );

  pba_link_ram #(
    .DEPTH (MAX_LINKS),
    .WIDTH (CAP_WIDTH),
    .AW    (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (ram_q)
  );

  assign m_axis_tdata = {7'b0, accepted};
  assign m_axis_tuser = range_error;

endmodule

// File: sv/pba_checker.sv
// ---------------------------------------------------------------------------
// pba_checker
// Port-level checks of the path bandwidth admission core, bound to the top.
// ---------------------------------------------------------------------------
`include "path_bandwidth_admission_core_assert.svh"

module pba_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [0:0] m_axis_tuser
);

  logic       stalled;
  logic       err_out;
  logic [8:0] payload;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign err_out = m_axis_tvalid && m_axis_tuser[0];
  assign payload = {m_axis_tuser, m_axis_tdata};

  // a stalled result holds its payload
  `PBA_ASSERT(a_out_hold, clk, rst, stalled |=> m_axis_tvalid && $stable(payload), "result changed under stall")

  // an out-of-range request is never admitted
  `PBA_ASSERT(a_err_rejects, clk, rst, err_out |-> !m_axis_tdata[0], "range error with accept")

  `PBA_ASSERT(a_pad_zero, clk, rst, m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'b0), "nonzero pad bits")

  // reset empties the output register
  `PBA_ASSERT_ALWAYS(a_rst_clear, clk, rst |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind path_bandwidth_admission_core pba_checker u_pba_checker (.*);

// File: dv/path_bandwidth_admission_checker.sv
// ----------------------------------------------------------------------------
// path_bandwidth_admission_checker
// Watches the config port and both streams of the admission core. It keeps a
// shadow of the link capacities and the chain length, predicts the verdict of
// every request as it is accepted and compares each delivered result, in
// order, against the oldest prediction.
// ----------------------------------------------------------------------------
module path_bandwidth_admission_checker
  import pba_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [63:0]      s_axis_tdata,
  input  logic [0:0]       s_axis_tuser,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [7:0]       m_axis_tdata,
  input  logic [0:0]       m_axis_tuser,
  output int               mismatches,
  output int               outstanding,
  output int               results_seen,
  output int               accepts_seen,
  output int               range_errors_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic accepted;
    logic range_error;
  } verdict_t;

  logic [CAP_WIDTH-1:0] capacity_shadow [MAX_LINKS];
  logic [CFG_W-1:0]     chain_links;
  verdict_t             verdict_q [$];

  task automatic report_mismatch(string what, logic got, logic want);
    $display("MISMATCH at result %0d: %s got %0b, expected %0b",
             results_seen, what, got, want);
    mismatches++;
  endtask

  // Decides one request and, when it fits, reserves its workload on the shadow links.
  function automatic verdict_t admit_request(req_t r);
    int                   lim;
    int                   lo;
    int                   hi;
    logic [CAP_WIDTH-1:0] least;
    verdict_t             v;
    v   = '0;
    lim = (chain_links > MAX_LINKS) ? MAX_LINKS : int'(chain_links);
    if (r.node_a > lim || r.node_b > lim) begin
      v.range_error = 1'b1;
      return v;
    end
    lo = (r.node_a < r.node_b) ? int'(r.node_a) : int'(r.node_b);
    hi = (r.node_a < r.node_b) ? int'(r.node_b) : int'(r.node_a);
    if (lo == hi) begin
      v.accepted = 1'b1;
      return v;
    end
    least = capacity_shadow[lo];
    for (int k = lo + 1; k < hi; k++) begin
      if (capacity_shadow[k] < least) least = capacity_shadow[k];
    end
    // full workload width in the compare, so a reservation never wraps
    if (CMP_W'(least) >= CMP_W'(r.amount)) begin
      for (int k = lo; k < hi; k++) begin
        capacity_shadow[k] = capacity_shadow[k] - CAP_WIDTH'(r.amount);
      end
      v.accepted = 1'b1;
    end
    return v;
  endfunction

  always @(posedge clk) begin : watch
    req_t     r;
    verdict_t want;
    if (rst) begin
      chain_links = CFG_W'(MAX_LINKS);
      verdict_q.delete();
    end else begin
      if (cfg_we) chain_links = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        r = req_t'({s_axis_tuser, s_axis_tdata});
        if (r.op == OP_LOAD) begin
          if (r.link_index < MAX_LINKS) capacity_shadow[r.link_index] = CAP_WIDTH'(r.amount);
        end else begin
          verdict_q.push_back(admit_request(r));
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no request pending, valid", 1'b1, 1'b0);
        end else begin
          want = verdict_q.pop_front();
          if (m_axis_tdata[0] !== want.accepted)
            report_mismatch("accepted", m_axis_tdata[0], want.accepted);
          if (m_axis_tuser[0] !== want.range_error)
            report_mismatch("range_error", m_axis_tuser[0], want.range_error);
          if (want.accepted) accepts_seen++;
          if (want.range_error) range_errors_seen++;
        end
      end
    end
    outstanding = verdict_q.size();
  end

endmodule

// File: dv/tb_path_bandwidth_admission_core.sv
// ----------------------------------------------------------------------------
// tb_path_bandwidth_admission_core
// Drives link loads, bandwidth requests and chain length settings into the
// admission core with random gaps and output stalls; the checker beside the
// block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module tb_path_bandwidth_admission_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pba_pkg::*;

  localparam int ITEMS        = 290;
  localparam int SETTLE       = 8;
  localparam int TAIL         = 2 * MAX_LINKS + 16;  // longest request latency
  // slowest run with full gaps and stalls
  localparam int CYCLE_LIMIT  = 4_000_000;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CFG_W-1:0]  cfg_wdata;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata;   // link_index, node_a, node_b, amount
  logic [0:0]        s_axis_tuser;   // op
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;   // accepted, zero pad
  logic [0:0]        m_axis_tuser;   // range_error

  int fail_count;
  int outstanding;
  int results_seen;
  int accepts_seen;
  int range_errors_seen;

  int chain_lim = MAX_LINKS;
  int chain_settings;
  int loads_sent;
  int items_sent;
  int cycle_count;
  bit steady_flow;
  bit link_loaded [MAX_LINKS];

  path_bandwidth_admission_core dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  path_bandwidth_admission_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .s_axis_tvalid     (s_axis_tvalid),
    .s_axis_tready     (s_axis_tready),
    .s_axis_tdata      (s_axis_tdata),
    .s_axis_tuser      (s_axis_tuser),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .m_axis_tdata      (m_axis_tdata),
    .m_axis_tuser      (m_axis_tuser),
    .mismatches        (fail_count),
    .outstanding       (outstanding),
    .results_seen      (results_seen),
    .accepts_seen      (accepts_seen),
    .range_errors_seen (range_errors_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result receiver: random stall before each result, none in steady flow
  initial begin : receiver
    int stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      stall = steady_flow ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
    end
  end

  function automatic logic [AMT_W-1:0] cap_value();
    case ($urandom_range(0, 9))
      8:       return '1;
      9:       return '0;
      6, 7:    return AMT_W'($urandom_range(0, 1000));
      default: return AMT_W'($urandom());
    endcase
  endfunction

  function automatic logic [AMT_W-1:0] workload_value();
    case ($urandom_range(0, 9))
      5, 6:    return AMT_W'($urandom_range(0, 1000));
      7:       return AMT_W'($urandom());
      8:       return '0;
      9:       return '1;
      default: return AMT_W'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  task automatic send_item(op_t op, logic [LINK_W-1:0] link, logic [NODE_W-1:0] na,
                           logic [NODE_W-1:0] nb, logic [AMT_W-1:0] amt);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {amt, nb, na, link};
    s_axis_tuser  <= op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // unused fields carry noise
  task automatic load_link(logic [LINK_W-1:0] idx, logic [AMT_W-1:0] cap);
    send_item(OP_LOAD, idx, NODE_W'($urandom_range(0, 2047)),
              NODE_W'($urandom_range(0, 2047)), cap);
    link_loaded[idx] = 1'b1;
    loads_sent++;
  endtask

  task automatic ask_path(logic [NODE_W-1:0] na, logic [NODE_W-1:0] nb,
                          logic [AMT_W-1:0] amt);
    send_item(OP_REQUEST, LINK_W'($urandom_range(0, 1023)), na, nb, amt);
  endtask

  // wait until every request has its result and the block is idle
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_chain(int v);
    settle();
    cfg_wdata <= CFG_W'(v);
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    chain_lim = (v > MAX_LINKS) ? MAX_LINKS : v;
    chain_settings++;
  endtask

  // Paths only cover links that were loaded; long chains get mostly short paths.
  task automatic random_request();
    int                kind;
    int                lo;
    int                hi;
    int                far;
    int                span;
    logic [NODE_W-1:0] na;
    logic [NODE_W-1:0] nb;
    kind = $urandom_range(0, 9);
    lo   = (chain_lim > 0) ? $urandom_range(0, chain_lim - 1) : 0;
    if (kind == 0) begin
      na = NODE_W'($urandom_range(chain_lim + 1, 2047));
      nb = NODE_W'($urandom_range(0, 2047));
    end else if (kind == 1 || chain_lim == 0 || !link_loaded[lo]) begin
      na = NODE_W'($urandom_range(0, chain_lim));
      nb = na;
    end else begin
      span = (chain_lim > 48 && $urandom_range(0, 15) != 0) ? 24 : chain_lim;
      far  = lo + 1;
      while (far < chain_lim && far - lo < span && link_loaded[far]) far++;
      hi = $urandom_range(lo + 1, far);
      na = NODE_W'(lo);
      nb = NODE_W'(hi);
    end
    if ($urandom_range(0, 1)) {na, nb} = {nb, na};
    ask_path(na, nb, workload_value());
  endtask

  initial begin : stimulus
    int n;
    int v;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_LOAD;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed, chain at its reset length
    load_link(0, 32'hFFFF_FFFF);
    load_link(1, 100);
    load_link(2, 32'h8000_0000);
    load_link(1022, 5);
    load_link(1023, 32'hFFFF_FFFF);
    ask_path(0, 0, 32'hFFFF_FFFF);      // empty path
    ask_path(1024, 1024, 0);
    ask_path(1025, 0, 1);               // node past the chain
    ask_path(0, 2047, 1);
    ask_path(2047, 2047, 1);            // range check wins over equal nodes
    ask_path(0, 1, 32'hFFFF_FFFF);      // exact fit drains link 0
    ask_path(1, 0, 1);
    ask_path(3, 1, 100);
    ask_path(1, 2, 0);
    ask_path(1024, 1022, 5);
    ask_path(1023, 1024, 32'hFFFF_FFFB);
    ask_path(1024, 1023, 32'hFFFF_FFFA);
    load_link(0, 32'h1234_5678);
    ask_path(2, 0, 1);

    set_chain(1);
    load_link(0, cap_value());
    repeat (10) random_request();

    set_chain(0);                       // only node 0 is valid
    ask_path(0, 0, workload_value());
    ask_path(0, 1, workload_value());
    ask_path(1, 1, workload_value());
    repeat (3) random_request();

    set_chain(2047);                    // clamps to the full store
    for (int k = MAX_LINKS - 8; k < MAX_LINKS; k++) begin
      load_link(LINK_W'(k), cap_value() | 32'h8000_0000);
    end
    ask_path(NODE_W'(MAX_LINKS - 8), 1024, workload_value() & 32'h0000_FFFF);
    ask_path(1024, NODE_W'(MAX_LINKS - 8), workload_value());
    repeat (20) random_request();

    set_chain(1500);
    repeat (10) random_request();
    set_chain(MAX_LINKS);
    repeat (10) random_request();

    while (items_sent < ITEMS) begin
      case ($urandom_range(0, 5))
        0:       v = MAX_LINKS;
        1:       v = $urandom_range(1025, 2047);
        default: v = $urandom_range(1, 64);
      endcase
      set_chain(v);
      steady_flow = ($urandom_range(0, 3) == 0);
      // refill capacities so requests keep fitting
      if (chain_lim <= 64) begin
        for (int k = 0; k < chain_lim; k++) load_link(LINK_W'(k), cap_value());
      end else begin
        repeat (16) load_link(LINK_W'($urandom_range(0, chain_lim - 1)), cap_value());
      end
      n = $urandom_range(15, 40);
      for (int i = 0; i < n && items_sent < ITEMS; i++) begin
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 4) == 0) load_link(LINK_W'($urandom_range(0, 1023)), cap_value());
          else load_link(LINK_W'($urandom_range(0, chain_lim - 1)), cap_value());
        end else begin
          random_request();
        end
      end
    end

    steady_flow = 1'b0;
    settle();
    repeat (TAIL) @(negedge clk);

    $display("%0d link loads, %0d request verdicts checked: %0d admitted, %0d out of range",
             loads_sent, results_seen, accepts_seen, range_errors_seen);
    $display("%0d chain lengths from 0 to 2047, paths over whole short chains and the store top",
             chain_settings + 1);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
